// ===== src/cd_pkg.sv =====
// Package for the circular deque: word and count widths, action codes,
// control states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cd_pkg;

  localparam int WORD_W    = 32;
  localparam int CNT_W     = 5;
  localparam int ACT_W     = 3;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_NOP        = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

// ===== src/cd_if.sv =====
// Request and response channel interfaces of the circular deque.
// Depends on cd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cd_req_if;
  logic                      valid;
  logic                      ready;
  logic [cd_pkg::ACT_W-1:0]  action;
  logic signed [cd_pkg::WORD_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface cd_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic signed [cd_pkg::WORD_W-1:0] front_value;
  logic signed [cd_pkg::WORD_W-1:0] rear_value;
  logic                      is_empty;
  logic                      is_full;
  logic [cd_pkg::CNT_W-1:0]  count;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, output count, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, input count, output ready);
endinterface
`default_nettype wire

// ===== src/cd_ring_mem.sv =====
// Ring storage of the deque: one write port, one registered read port.
// Depends on cd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cd_ring_mem #(
  parameter int DEPTH = cd_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  wire logic [cd_pkg::WORD_W-1:0]   wr_data,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic      [cd_pkg::WORD_W-1:0]   rd_data
);

  logic [cd_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/circular_deque_unit.sv =====
// Circular deque top level: control, indexes, front/rear word cache, result register.
// Depends on cd_pkg, cd_if and cd_ring_mem.
`timescale 1ns / 1ps
`default_nettype none
// A double-ended queue of signed 32-bit words in a ring of DEPTH entries, of which
// the capacity register selects how many are used (saturated to 1..DEPTH, written
// only while empty; a write resets both indexes). Push, no-change, refused actions
// and the pop of the last word are answered from the idle state; a pop that leaves
// words behind goes through the read state, since the new front or rear word comes
// from the ring memory, whose read port is registered. The front and rear words are
// cached in registers, so no action needs more than one memory read. A new request
// is taken only while idle and the output register is empty or is drained in the same cycle.
module circular_deque_unit #(
  parameter int DEPTH = cd_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [cd_pkg::CNT_W-1:0]   cfg_wr_data,
  cd_req_if.sink                          req,
  cd_rsp_if.source                        rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
  localparam int CFG_W = ((CAP_W > cd_pkg::CNT_W) ? CAP_W : cd_pkg::CNT_W) + 1;
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(DEPTH);

  cd_pkg::state_t state, state_next;

  logic [IDX_W-1:0]            head, head_next;
  logic [IDX_W-1:0]            tail, tail_next;
  logic [CAP_W-1:0]            held, held_next;
  logic [CAP_W-1:0]            cap;
  logic [cd_pkg::WORD_W-1:0]   front_q, front_next;
  logic [cd_pkg::WORD_W-1:0]   rear_q, rear_next;
  logic                        rd_front, rd_front_next;

  logic                        rsp_valid, rsp_valid_next;
  logic                        ok_r, ok_next;
  logic [cd_pkg::WORD_W-1:0]   front_r, front_r_next;
  logic [cd_pkg::WORD_W-1:0]   rear_r, rear_r_next;
  logic                        empty_r, empty_next;
  logic                        full_r, full_next;
  logic [CAP_W-1:0]            count_r, count_next;

  logic                        wr_en, rd_en;
  logic [IDX_W-1:0]            wr_addr, rd_addr;
  logic [cd_pkg::WORD_W-1:0]   rd_data;

  logic                        accept;
  logic [CFG_W-1:0]            cfg_ext;
  logic [CAP_W-1:0]            cap_sat;

  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] ie;
    logic [CMP_W-1:0] ce;
    ie = CMP_W'(idx);
    ce = CMP_W'(c);
    if (idx == '0 || ie >= ce) begin
      return IDX_W'(ce - CMP_W'(1));
    end
    return idx - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] ie;
    ie = CMP_W'(idx) + CMP_W'(1);
    if (ie >= CMP_W'(c)) begin
      return '0;
    end
    return IDX_W'(ie);
  endfunction

  cd_ring_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready = (state == cd_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // capacity saturation to 1..DEPTH
  always_comb begin
    cfg_ext = CFG_W'(cfg_wr_data);
    if (cfg_wr_data == '0) begin
      cap_sat = CAP_W'(1);
    end else if (cfg_ext > CFG_W'(DEPTH)) begin
      cap_sat = CAP_RST;
    end else begin
      cap_sat = CAP_W'(cfg_wr_data);
    end
  end

  always_comb begin
    logic full;
    logic empty;
    logic [cd_pkg::ACT_W-1:0] act;
    full  = (held >= cap);
    empty = (held == '0);
    act   = req.action;

    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    held_next      = held;
    front_next     = front_q;
    rear_next      = rear_q;
    rd_front_next  = rd_front;
    rsp_valid_next = rsp_valid && !rsp.ready;
    ok_next        = ok_r;
    front_r_next   = front_r;
    rear_r_next    = rear_r;
    empty_next     = empty_r;
    full_next      = full_r;
    count_next     = count_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state)
      cd_pkg::ST_IDLE: begin
        if (accept) begin
          ok_next = 1'b0;
          case (act)
            cd_pkg::ACT_PUSH_FRONT, cd_pkg::ACT_PUSH_REAR: begin
              if (!full) begin
                ok_next = 1'b1;
                wr_en   = 1'b1;
                if (empty) begin
                  head_next  = '0;
                  tail_next  = '0;
                  wr_addr    = '0;
                  front_next = req.value;
                  rear_next  = req.value;
                end else if (act == cd_pkg::ACT_PUSH_FRONT) begin
                  head_next  = step_back(head, cap);
                  wr_addr    = head_next;
                  front_next = req.value;
                end else begin
                  tail_next  = step_fwd(tail, cap);
                  wr_addr    = tail_next;
                  rear_next  = req.value;
                end
                held_next = held + CAP_W'(1);
              end
            end
            cd_pkg::ACT_POP_FRONT, cd_pkg::ACT_POP_REAR: begin
              if (!empty) begin
                ok_next = 1'b1;
                if (held == CAP_W'(1)) begin
                  head_next = '0;
                  tail_next = '0;
                end else if (act == cd_pkg::ACT_POP_FRONT) begin
                  head_next     = step_fwd(head, cap);
                  rd_en         = 1'b1;
                  rd_addr       = head_next;
                  rd_front_next = 1'b1;
                end else begin
                  tail_next     = step_back(tail, cap);
                  rd_en         = 1'b1;
                  rd_addr       = tail_next;
                  rd_front_next = 1'b0;
                end
                held_next = held - CAP_W'(1);
              end
            end
            cd_pkg::ACT_NOP: begin
              ok_next = 1'b1;
            end
            default: begin
              ok_next = 1'b0;
            end
          endcase

          empty_next = (held_next == '0);
          full_next  = (held_next >= cap);
          count_next = held_next;
          if (rd_en) begin
            state_next = cd_pkg::ST_READ;
          end else begin
            rsp_valid_next = 1'b1;
            front_r_next   = (held_next == '0) ? '1 : front_next;
            rear_r_next    = (held_next == '0) ? '1 : rear_next;
          end
        end
      end
      cd_pkg::ST_READ: begin
        // output register is free here: it was free or drained at the request
        if (rd_front) begin
          front_next = rd_data;
        end else begin
          rear_next = rd_data;
        end
        front_r_next   = rd_front ? rd_data : front_q;
        rear_r_next    = rd_front ? rear_q : rd_data;
        rsp_valid_next = 1'b1;
        state_next     = cd_pkg::ST_IDLE;
      end
      default: begin
        state_next = cd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cd_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      cap       <= CAP_RST;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_wr_en && held == '0) begin
        cap  <= cap_sat;
        head <= '0;
        tail <= '0;
      end else begin
        head <= head_next;
        tail <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_q  <= front_next;
    rear_q   <= rear_next;
    rd_front <= rd_front_next;
    ok_r     <= ok_next;
    front_r  <= front_r_next;
    rear_r   <= rear_r_next;
    empty_r  <= empty_next;
    full_r   <= full_next;
    count_r  <= count_next;
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = ok_r;
  assign rsp.front_value = front_r;
  assign rsp.rear_value  = rear_r;
  assign rsp.is_empty    = empty_r;
  assign rsp.is_full     = full_r;
  assign rsp.count       = cd_pkg::CNT_W'(count_r);

endmodule
`default_nettype wire

// ===== test/circular_deque_unit_tb.sv =====
// Self-checking testbench for circular_deque_unit: directed and random deque
// requests, scored against an in-bench deque predictor, random stalls on both sides.
// Depends on cd_pkg, cd_if and circular_deque_unit.
`timescale 1ns / 1ps
module circular_deque_unit_tb;
  import cd_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam logic [ACT_W-1:0]         ACT_LAST   = '1;
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -1;
  localparam logic signed [WORD_W-1:0] WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] rear;
    logic                     empty;
    logic                     full;
    logic [CNT_W-1:0]         count;
  } deque_view_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  cd_req_if req_ch();
  cd_rsp_if rsp_ch();

  circular_deque_unit #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  always #10 clk = ~clk;

  // deque predictor state
  logic [WORD_W-1:0] ring_words [DEPTH];
  int unsigned head_at    = 0;
  int unsigned tail_at    = 0;
  int unsigned words_held = 0;
  int unsigned cap_now    = DEPTH;

  deque_view_t pending_results[$];
  int fail_count = 0;
  int max_gap    = 3;
  int rsp_wait   = 0;
  bit req_on     = 1'b0;

  function automatic int unsigned ring_prev(int unsigned idx);
    return (idx == 0 || idx >= cap_now) ? cap_now - 1 : idx - 1;
  endfunction

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= cap_now) ? 0 : idx + 1;
  endfunction

  function automatic deque_view_t deque_step(logic [ACT_W-1:0] act, logic [WORD_W-1:0] word);
    deque_view_t v;
    logic ok;
    ok = 1'b0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (words_held < cap_now) begin
          if (words_held == 0) begin
            head_at = 0;
            tail_at = 0;
            ring_words[0] = word;
          end else if (act == ACT_PUSH_FRONT) begin
            head_at = ring_prev(head_at);
            ring_words[head_at] = word;
          end else begin
            tail_at = ring_next(tail_at);
            ring_words[tail_at] = word;
          end
          words_held++;
          ok = 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (words_held != 0) begin
          if (words_held == 1) begin
            head_at = 0;
            tail_at = 0;
          end else if (act == ACT_POP_FRONT) begin
            head_at = ring_next(head_at);
          end else begin
            tail_at = ring_prev(tail_at);
          end
          words_held--;
          ok = 1'b1;
        end
      end
      ACT_NOP: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    v.ok    = ok;
    v.empty = (words_held == 0);
    v.front = v.empty ? EMPTY_WORD : ring_words[head_at];
    v.rear  = v.empty ? EMPTY_WORD : ring_words[tail_at];
    v.full  = (words_held >= cap_now);
    v.count = words_held[CNT_W-1:0];
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return EMPTY_WORD;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACT_W'($urandom_range(int'(ACT_NOP) + 1, int'(ACT_LAST)));
    if (r < 8) return ACT_NOP;
    if (r < 8 + push_pct * 92 / 100)
      return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
  endfunction

  task automatic send_request(logic [ACT_W-1:0] act, logic [WORD_W-1:0] word);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      if (req_on) req_ch.valid <= 1'b0;
      req_on = 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= word;
    req_on = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(deque_step(act, word));
  endtask

  task automatic stop_requests();
    if (req_on) req_ch.valid <= 1'b0;
    req_on = 1'b0;
  endtask

  task automatic drain_and_settle();
    stop_requests();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle; ignored by the block while words are held
  task automatic write_capacity(logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    if (words_held == 0) begin
      if (v == 0) cap_now = 1;
      else if (v > DEPTH) cap_now = DEPTH;
      else cap_now = v;
      head_at = 0;
      tail_at = 0;
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cap_code, int n_items);
    int left;
    int burst;
    int push_pct;
    while (words_held != 0)
      send_request($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, pick_word());
    drain_and_settle();
    write_capacity(cap_code);
    left = n_items;
    push_pct = 85;
    while (left > 0) begin
      burst = $urandom_range(cap_now, 2 * cap_now + 8);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 79) == 0) drain_and_settle();
        send_request(pick_action(push_pct), pick_word());
        burst--;
        left--;
      end
      push_pct = 100 - push_pct;
    end
  endtask

  task automatic test_empty_and_unknown();
    send_request(ACT_POP_FRONT, pick_word());
    send_request(ACT_POP_REAR, pick_word());
    send_request(ACT_NOP, pick_word());
    for (int a = int'(ACT_NOP) + 1; a <= int'(ACT_LAST); a++)
      send_request(a[ACT_W-1:0], pick_word());
  endtask

  task automatic test_push_pop_ends();
    send_request(ACT_PUSH_REAR, WORD_MAX);
    send_request(ACT_PUSH_FRONT, WORD_MIN);
    send_request(ACT_PUSH_REAR, '0);
    send_request(ACT_PUSH_FRONT, EMPTY_WORD);
    send_request(ACT_NOP, '0);
    send_request(ACT_POP_REAR, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_POP_REAR, '0);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_PUSH_REAR, 32'h5555_5555);
    send_request(ACT_PUSH_FRONT, 32'haaaa_aaaa);
    drain_and_settle();
    write_capacity(5'd3);
    send_request(ACT_POP_FRONT, '0);
    send_request(ACT_POP_REAR, '0);
  endtask

  task automatic test_capacity_limits();
    drain_and_settle();
    write_capacity('0);
    send_request(ACT_PUSH_REAR, 32'h1234_5678);
    send_request(ACT_PUSH_FRONT, 32'h8765_4321);
    send_request(ACT_NOP, '0);
    send_request(ACT_POP_FRONT, '0);
    drain_and_settle();
    write_capacity('1);
  endtask

  task automatic test_random_traffic();
    max_gap = 3;
    run_phase(5'd16, 90);
    run_phase(5'd2, 70);
    run_phase(5'd1, 50);
    run_phase(5'd3, 70);
    max_gap = 0;
    run_phase(5'd16, 90);
    max_gap = 3;
    run_phase(5'd0, 40);
    run_phase(5'd31, 90);
    run_phase(5'd17, 60);
    run_phase(CNT_W'($urandom_range(1, 16)), 60);
    run_phase(CNT_W'($urandom_range(0, 31)), 40);
  endtask

  // response side: random stall after every result, scoring on each handshake
  always @(posedge clk) begin
    deque_view_t got;
    deque_view_t want;
    if (rst) begin
      rsp_wait = 0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok    = rsp_ch.ok;
        got.front = rsp_ch.front_value;
        got.rear  = rsp_ch.rear_value;
        got.empty = rsp_ch.is_empty;
        got.full  = rsp_ch.is_full;
        got.count = rsp_ch.count;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                     $realtime, got.ok, got.front, got.rear, got.empty, got.full, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                       want.ok, want.front, want.rear, want.empty, want.full, want.count);
              $display("  actual   ok=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                       got.ok, got.front, got.rear, got.empty, got.full, got.count);
            end
          end
        end
        rsp_wait = $urandom_range(0, max_gap);
      end else if (rsp_wait > 0) begin
        rsp_wait--;
      end
      rsp_ch.ready <= (rsp_wait == 0);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_NOP;
    req_ch.value  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_unknown();
    test_push_pop_ends();
    test_capacity_limits();
    test_random_traffic();
    drain_and_settle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cd_pkg.sv
src/cd_if.sv
src/cd_ring_mem.sv
src/circular_deque_unit.sv
test/circular_deque_unit_tb.sv
